[hw/rtl/lbp_pkg.sv]
// lbp_pkg: shared types and constants for the lsb-first bit packer
// holds the operation codes and the encoder result struct
// no dependencies
package lbp_pkg;

  localparam int MAX_FIELD_BITS = 32;
  localparam int VALUE_BITS     = 32;
  localparam int MAX_BYTES      = 5;

  localparam logic [6:0] GROUP_MASK = 7'h7F;
  localparam logic       MORE_FLAG  = 1'b1;

  typedef enum logic [1:0] {
    OP_PUT_BITS    = 2'd0,
    OP_PUT_VARINT  = 2'd1,
    OP_PUT_ALIGNED = 2'd2,
    OP_FLUSH       = 2'd3
  } op_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] byte_data;  // byte 0 goes out first
    logic [2:0]                count;
    logic [7:0]                partial;
    logic [2:0]                filled;
  } enc_result_t;

endpackage

[hw/rtl/lbp_encode.sv]
// lbp_encode: turns one request plus the pending partial byte into up to five
// stream bytes and the next partial byte state
// depends on lbp_pkg
module lbp_encode import lbp_pkg::*; (
  input  op_t         op,
  input  logic [5:0]  bit_count,
  input  logic [2:0]  byte_count,
  input  logic [31:0] value,
  input  logic [7:0]  partial,
  input  logic [2:0]  filled,
  output enc_result_t result
);

  logic [5:0]       nb;
  logic [31:0]      bits_mask;
  logic [34:0]      value_ext;
  logic [2:0]       groups;
  logic [4:0][7:0]  grp;
  logic [47:0]      word;
  logic [47:0]      stream;
  logic [5:0]       total_bits;
  logic [2:0]       nbytes;
  logic [2:0]       k;
  logic [31:0]      al;
  logic [3:0][7:0]  al_bytes;
  logic             pre;

  // clamp the bit count to the field and value widths
  always_comb begin
    nb = bit_count;
    if (nb > 6'(MAX_FIELD_BITS)) nb = 6'(MAX_FIELD_BITS);
    if (nb > 6'(VALUE_BITS)) nb = 6'(VALUE_BITS);
    bits_mask = (nb >= 6'd32) ? '1 : ((32'h1 << nb) - 32'h1);
  end

  // number of 7-bit groups for the varint
  always_comb begin
    if (|value[31:28])      groups = 3'd5;
    else if (|value[27:21]) groups = 3'd4;
    else if (|value[20:14]) groups = 3'd3;
    else if (|value[13:7])  groups = 3'd2;
    else                    groups = 3'd1;
  end

  assign value_ext = {3'b000, value};

  always_comb begin
    for (int i = 0; i < MAX_BYTES; i++) begin
      grp[i][6:0] = value_ext[7*i +: 7] & GROUP_MASK;
      grp[i][7]   = (3'(i + 1) < groups) ? MORE_FLAG : 1'b0;
    end
  end

  // bit path: new bits land above the filled bits of the partial byte
  always_comb begin
    if (op == OP_PUT_VARINT) word = {8'h00, grp};
    else                     word = {16'h0000, value & bits_mask};
    stream     = (word << filled) | {40'h0, partial};
    total_bits = {3'b000, filled} + nb;
    nbytes     = (op == OP_PUT_VARINT) ? groups : total_bits[5:3];
  end

  // aligned path: big-endian bytes, high bytes beyond the count dropped
  always_comb begin
    k        = (byte_count > 3'd4) ? 3'd4 : byte_count;
    al       = value << {(3'd4 - k), 3'b000};
    al_bytes = al;
    pre      = (filled != 3'd0);
  end

  always_comb begin
    result = '0;
    unique case (op)
      OP_PUT_BITS, OP_PUT_VARINT: begin
        for (int i = 0; i < MAX_BYTES; i++) begin
          result.byte_data[i] = stream[8*i +: 8];
        end
        result.count   = nbytes;
        result.partial = stream[{nbytes, 3'b000} +: 8];
        result.filled  = (op == OP_PUT_VARINT) ? filled : total_bits[2:0];
      end
      OP_PUT_ALIGNED, OP_FLUSH: begin
        if (pre) begin
          result.byte_data[0] = partial;
          result.byte_data[1] = al_bytes[3];
          result.byte_data[2] = al_bytes[2];
          result.byte_data[3] = al_bytes[1];
          result.byte_data[4] = al_bytes[0];
        end else begin
          result.byte_data[0] = al_bytes[3];
          result.byte_data[1] = al_bytes[2];
          result.byte_data[2] = al_bytes[1];
          result.byte_data[3] = al_bytes[0];
          result.byte_data[4] = 8'h00;
        end
        result.count   = {2'b00, pre} + ((op == OP_PUT_ALIGNED) ? k : 3'd0);
        result.partial = 8'h00;
        result.filled  = 3'd0;
      end
      default: begin
        result = '0;
      end
    endcase
  end

endmodule

[hw/rtl/lsb_bit_packer_with_varint.sv]
// lsb_bit_packer_with_varint: top level of the lsb-first bit packer with varints
// depends on lbp_pkg and lbp_encode
//
// Each request is registered, encoded combinationally together with the pending
// partial byte, and its bytes (zero to five) are loaded into a five-entry
// output buffer that drives the master side one byte per cycle while m_tready
// is high, tlast on the final byte of the request. A request that yields at most
// one byte is taken every cycle while m_tready is high; a request that yields more
// bytes holds the next registered request until the one-byte output port has
// drained the byte buffer. With the buffer free, a request passes through the
// input register and then the output buffer before its first byte is presented.
// Requests that yield no byte only update the partial byte state.
module lsb_bit_packer_with_varint import lbp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // bit_count[5:0], byte_count[8:6], value[40:9], zero fill
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic        m_tlast
);

  logic                      in_valid;
  op_t                       in_op;
  logic [5:0]                in_bit_count;
  logic [2:0]                in_byte_count;
  logic [31:0]               in_value;
  logic [MAX_BYTES-1:0][7:0] ob_data;
  logic [2:0]                ob_count;
  logic [7:0]                partial;
  logic [2:0]                filled;
  enc_result_t               enc;
  logic                      load;

  lbp_encode u_encode (
    .op         (in_op),
    .bit_count  (in_bit_count),
    .byte_count (in_byte_count),
    .value      (in_value),
    .partial    (partial),
    .filled     (filled),
    .result     (enc)
  );

  // buffer takes the next request when empty or when its last byte leaves now
  assign load     = in_valid && ((ob_count == 3'd0) || ((ob_count == 3'd1) && m_tready));
  assign s_tready = !in_valid || load;

  assign m_tvalid = (ob_count != 3'd0);
  assign m_tlast  = (ob_count == 3'd1);
  assign m_tdata  = ob_data[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      ob_count <= 3'd0;
      partial  <= 8'h00;
      filled   <= 3'd0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (load) begin
        ob_count <= enc.count;
        partial  <= enc.partial;
        filled   <= enc.filled;
      end else if (m_tvalid && m_tready) begin
        ob_count <= ob_count - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op         <= op_t'(s_tuser);
      in_bit_count  <= s_tdata[5:0];
      in_byte_count <= s_tdata[8:6];
      in_value      <= s_tdata[40:9];
    end
    if (load) begin
      ob_data <= enc.byte_data;
    end else if (m_tvalid && m_tready) begin
      ob_data <= {8'h00, ob_data[MAX_BYTES-1:1]};
    end
  end

endmodule

[hw/rtl/lbp_checker.sv]
// lbp_checker: port-level checks for lsb_bit_packer_with_varint
// bound to the top level; depends on nothing else
module lbp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [47:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast
);

  // stalled output byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output byte changed while stalled");

  // reset leaves nothing to send and the input open
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("not idle after reset");

  // with no byte pending the block never stalls its input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // bytes of one request follow without gaps
  a_burst_contiguous: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("gap inside a request's bytes");

endmodule

bind lsb_bit_packer_with_varint lbp_checker u_lbp_checker (.*);
